[rtl/ipbl_pkg.sv]
// shared types, constants and codes of the ipv4 prefix blocklist filter
package ipbl_pkg;

   // table sizes
   localparam int FS_ENTRIES  = 16;
   localparam int PFX_ENTRIES = 16;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // frame layout and protocol constants
   localparam logic [15:0] MIN_FRAME_LEN     = 16'd42;
   localparam logic [15:0] MIN_TCP_FRAME_LEN = 16'd54;
   localparam logic [15:0] IPV4_ETHERTYPE    = 16'h0800;
   localparam logic [7:0]  L4_PROTO_TCP      = 8'd6;
   localparam logic [7:0]  L4_PROTO_UDP      = 8'd17;
   localparam logic [5:0]  ADDR_BITS         = 6'd32;

   localparam logic [15:0] POS_ETYPE_HI = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO = 16'd13;
   localparam logic [15:0] POS_PROTO    = 16'd23;
   localparam logic [15:0] POS_SRC_FIRST = 16'd26;
   localparam logic [15:0] POS_SRC_LAST  = 16'd29;
   localparam logic [15:0] POS_DPORT_HI = 16'd36;
   localparam logic [15:0] POS_DPORT_LO = 16'd37;

   // input item modes
   localparam logic [1:0] MODE_FRAME  = 2'd0;
   localparam logic [1:0] MODE_WR_FS  = 2'd1;
   localparam logic [1:0] MODE_WR_PFX = 2'd2;

   // verdicts and reasons
   localparam logic       VERDICT_PASS = 1'b0;
   localparam logic       VERDICT_DROP = 1'b1;
   localparam logic [2:0] REASON_SHORT    = 3'd0;
   localparam logic [2:0] REASON_NOT_IPV4 = 3'd1;
   localparam logic [2:0] REASON_FAILSAFE = 3'd2;
   localparam logic [2:0] REASON_PREFIX   = 3'd3;
   localparam logic [2:0] REASON_NO_MATCH = 3'd4;

   // kinds of queued command
   typedef enum logic [1:0] {
      CMD_JUDGE,
      CMD_WR_FS,
      CMD_WR_PFX
   } cmd_kind_type;

   // one queued command: a table write or a parsed frame summary
   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   index;
      logic         valid;
      logic [7:0]   protocol;
      logic [15:0]  port;
      logic [31:0]  address;
      logic [5:0]   prefix_length;
      logic         short_frame;
      logic         not_ipv4;
      logic         l4;
   } cmd_type;

endpackage

[rtl/ipbl_if.sv]
// valid/ready channel interfaces for request and response beats

interface ipbl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  byte_value;
   logic        last_byte;
   logic [3:0]  entry_index;
   logic        entry_valid;
   logic [7:0]  entry_protocol;
   logic [15:0] entry_port;
   logic [31:0] entry_address;
   logic [5:0]  entry_prefix_length;

   modport source (
      output valid, mode, byte_value, last_byte, entry_index, entry_valid,
             entry_protocol, entry_port, entry_address, entry_prefix_length,
      input  ready
   );
   modport sink (
      input  valid, mode, byte_value, last_byte, entry_index, entry_valid,
             entry_protocol, entry_port, entry_address, entry_prefix_length,
      output ready
   );
endinterface

interface ipbl_rsp_if;
   logic       valid;
   logic       ready;
   logic       verdict;
   logic [2:0] reason;

   modport source (output valid, verdict, reason, input ready);
   modport sink (input valid, verdict, reason, output ready);
endinterface

[rtl/ipbl_front.sv]
// front end: takes request beats, parses frame headers, queues commands
module ipbl_front import ipbl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ipbl_req_if.sink    req_chan,
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   logic [15:0] count_ff, count_in;
   logic [15:0] etype_ff, etype_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [15:0] dport_ff, dport_in;
   logic        accept;
   logic        byte_beat;
   logic        is_tcp;
   logic        is_udp;
   logic [5:0]  plen_clamped;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign byte_beat      = accept && (req_chan.mode == MODE_FRAME);

   // header capture by byte position, count saturates
   always_comb begin
      etype_in = etype_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dport_in = dport_ff;
      if (count_ff == POS_ETYPE_HI || count_ff == POS_ETYPE_LO) begin
         etype_in = {etype_ff[7:0], req_chan.byte_value};
      end else if (count_ff == POS_PROTO) begin
         proto_in = req_chan.byte_value;
      end else if (count_ff >= POS_SRC_FIRST && count_ff <= POS_SRC_LAST) begin
         src_in = {src_ff[23:0], req_chan.byte_value};
      end else if (count_ff == POS_DPORT_HI || count_ff == POS_DPORT_LO) begin
         dport_in = {dport_ff[7:0], req_chan.byte_value};
      end
      count_in = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;
   end

   // frame state, cleared after the final beat
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         etype_ff <= '0;
         proto_ff <= '0;
         src_ff   <= '0;
         dport_ff <= '0;
      end else if (byte_beat) begin
         if (req_chan.last_byte) begin
            count_ff <= '0;
            etype_ff <= '0;
            proto_ff <= '0;
            src_ff   <= '0;
            dport_ff <= '0;
         end else begin
            count_ff <= count_in;
            etype_ff <= etype_in;
            proto_ff <= proto_in;
            src_ff   <= src_in;
            dport_ff <= dport_in;
         end
      end
   end

   assign is_tcp       = (proto_in == L4_PROTO_TCP);
   assign is_udp       = (proto_in == L4_PROTO_UDP);
   assign plen_clamped = (req_chan.entry_prefix_length > ADDR_BITS) ?
                         ADDR_BITS : req_chan.entry_prefix_length;

   // build the queued command
   always_comb begin
      q_push = 1'b0;
      q_cmd  = '0;
      case (req_chan.mode)
         MODE_FRAME: begin
            q_push            = accept && req_chan.last_byte;
            q_cmd.kind        = CMD_JUDGE;
            q_cmd.protocol    = proto_in;
            q_cmd.port        = (is_tcp && count_in < MIN_TCP_FRAME_LEN) ? 16'd0 : dport_in;
            q_cmd.address     = src_in;
            q_cmd.short_frame = (count_in < MIN_FRAME_LEN);
            q_cmd.not_ipv4    = (etype_in != IPV4_ETHERTYPE);
            q_cmd.l4          = is_tcp || is_udp;
         end
         MODE_WR_FS: begin
            q_push         = accept;
            q_cmd.kind     = CMD_WR_FS;
            q_cmd.index    = req_chan.entry_index;
            q_cmd.valid    = req_chan.entry_valid;
            q_cmd.protocol = req_chan.entry_protocol;
            q_cmd.port     = req_chan.entry_port;
         end
         MODE_WR_PFX: begin
            q_push              = accept;
            q_cmd.kind          = CMD_WR_PFX;
            q_cmd.index         = req_chan.entry_index;
            q_cmd.valid         = req_chan.entry_valid;
            q_cmd.address       = req_chan.entry_address;
            q_cmd.prefix_length = plen_clamped;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

endmodule

[rtl/ipbl_queue.sv]
// short command queue between front and back
module ipbl_queue import ipbl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // checks
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid) else $error("pop from empty queue");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");

endmodule

[rtl/ipbl_back.sv]
// back end: applies table writes and judges frames against the tables
module ipbl_back import ipbl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  cmd_type     q_cmd,
   output logic        q_pop,
   ipbl_rsp_if.source  rsp_chan
);

   logic [FS_ENTRIES-1:0]  fs_valid_ff;
   logic [7:0]             fs_proto_ff [FS_ENTRIES];
   logic [15:0]            fs_port_ff  [FS_ENTRIES];
   logic [PFX_ENTRIES-1:0] pfx_valid_ff;
   logic [31:0]            pfx_addr_ff [PFX_ENTRIES];
   logic [31:0]            pfx_mask_ff [PFX_ENTRIES];

   logic       rsp_valid_ff;
   logic       verdict_ff, verdict_in;
   logic [2:0] reason_ff, reason_in;
   logic       out_free;
   logic       judge_pop;
   logic       wr_fs;
   logic       wr_pfx;
   logic       fs_hit;
   logic       pfx_hit;
   logic [31:0] new_mask;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop     = q_valid && ((q_cmd.kind != CMD_JUDGE) || out_free);
   assign judge_pop = q_pop && (q_cmd.kind == CMD_JUDGE);
   assign wr_fs     = q_pop && (q_cmd.kind == CMD_WR_FS);
   assign wr_pfx    = q_pop && (q_cmd.kind == CMD_WR_PFX);
   // length 0 gives an empty mask, 32 a full one
   assign new_mask  = ~(32'hFFFF_FFFF >> q_cmd.prefix_length);

   // entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_valid_ff  <= '0;
         pfx_valid_ff <= '0;
      end else begin
         for (int i = 0; i < FS_ENTRIES; i++) begin
            if (wr_fs && int'(q_cmd.index) == i) begin
               fs_valid_ff[i] <= q_cmd.valid;
            end
         end
         for (int i = 0; i < PFX_ENTRIES; i++) begin
            if (wr_pfx && int'(q_cmd.index) == i) begin
               pfx_valid_ff[i] <= q_cmd.valid;
            end
         end
      end
   end

   // entry contents
   always_ff @(posedge clock) begin
      for (int i = 0; i < FS_ENTRIES; i++) begin
         if (wr_fs && int'(q_cmd.index) == i) begin
            fs_proto_ff[i] <= q_cmd.protocol;
            fs_port_ff[i]  <= q_cmd.port;
         end
      end
      for (int i = 0; i < PFX_ENTRIES; i++) begin
         if (wr_pfx && int'(q_cmd.index) == i) begin
            pfx_addr_ff[i] <= q_cmd.address;
            pfx_mask_ff[i] <= new_mask;
         end
      end
   end

   // parallel table compares
   always_comb begin
      fs_hit = 1'b0;
      for (int i = 0; i < FS_ENTRIES; i++) begin
         fs_hit = fs_hit | (fs_valid_ff[i] && fs_proto_ff[i] == q_cmd.protocol &&
                            fs_port_ff[i] == q_cmd.port);
      end
      pfx_hit = 1'b0;
      for (int i = 0; i < PFX_ENTRIES; i++) begin
         pfx_hit = pfx_hit | (pfx_valid_ff[i] &&
                              ((q_cmd.address ^ pfx_addr_ff[i]) & pfx_mask_ff[i]) == '0);
      end
   end

   // verdict priority
   always_comb begin
      if (q_cmd.short_frame) begin
         verdict_in = VERDICT_DROP;
         reason_in  = REASON_SHORT;
      end else if (q_cmd.not_ipv4) begin
         verdict_in = VERDICT_PASS;
         reason_in  = REASON_NOT_IPV4;
      end else if (q_cmd.l4 && fs_hit) begin
         verdict_in = VERDICT_PASS;
         reason_in  = REASON_FAILSAFE;
      end else if (pfx_hit) begin
         verdict_in = VERDICT_DROP;
         reason_in  = REASON_PREFIX;
      end else begin
         verdict_in = VERDICT_PASS;
         reason_in  = REASON_NO_MATCH;
      end
   end

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= judge_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (judge_pop) begin
         verdict_ff <= verdict_in;
         reason_ff  <= reason_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.verdict = verdict_ff;
   assign rsp_chan.reason  = reason_ff;

   // checks
   a_judge_shows: assert property (@(posedge clock) disable iff (reset)
      judge_pop |=> rsp_valid_ff) else $error("judged frame gave no response beat");

endmodule

[rtl/ipv4_prefix_blocklist_filter_top.sv]
// top level of the ipv4 source prefix blocklist filter
// Takes one request beat per cycle unless the queue is full: frame bytes in
// wire order (mode 0) or writes of failsafe and prefix table entries (modes
// 1 and 2). One response beat per frame carries its verdict and reason; the
// frame passes through the queue and the output register after its final
// byte is accepted. The front end parses header fields and queues a summary
// per frame and one command per table write into a four-entry queue; the
// back end applies writes and compares summaries against all sixteen entries
// of each table in parallel, so with no response stall the sustained rate is
// one beat per cycle, set by that single compare stage. Table writes act in
// order with frames. Tables start empty after reset with no clearing pass.
module ipv4_prefix_blocklist_filter_top import ipbl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ipbl_req_if.sink   req_chan,
   ipbl_rsp_if.source rsp_chan
);

   logic    q_full;
   logic    q_push;
   cmd_type q_push_cmd;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_pop_cmd;

   ipbl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_push_cmd)
   );

   ipbl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_pop_cmd)
   );

   ipbl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_cmd    (q_pop_cmd),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
